### rtl/rbnp_pkg.sv
// ----------------------------------------------------------------------------
// rbnp_pkg
// Shared widths, register indexes and defaults of the ray/box nearest pick.
// ----------------------------------------------------------------------------
package rbnp_pkg;

    localparam int MaxSlotsDefault = 1024;

    localparam int CoordW  = 32;
    localparam int ExtW    = 31;
    localparam int SlotW   = 10;
    localparam int ThrW    = 16;
    localparam int CfgAddrW = 3;
    localparam int BoundW  = 34;
    localparam int DiffW   = 35;
    localparam int NumW    = 45;
    localparam int CntW    = 6;
    localparam int TW      = 34;

    localparam int InDataW  = 200;
    localparam int OutDataW = 48;

    localparam logic [CfgAddrW-1:0] RegOrgX = 3'd0;
    localparam logic [CfgAddrW-1:0] RegOrgY = 3'd1;
    localparam logic [CfgAddrW-1:0] RegOrgZ = 3'd2;
    localparam logic [CfgAddrW-1:0] RegDirX = 3'd3;
    localparam logic [CfgAddrW-1:0] RegDirY = 3'd4;
    localparam logic [CfgAddrW-1:0] RegDirZ = 3'd5;
    localparam logic [CfgAddrW-1:0] RegFar  = 3'd6;
    localparam logic [CfgAddrW-1:0] RegThr  = 3'd7;

    localparam logic [31:0] DirZReset = 32'hFFFF_F000;
    localparam logic [31:0] FarReset  = 32'd4096000000;
    localparam logic [ThrW-1:0] ThrReset = 16'd1;

endpackage

### rtl/ray_box_nearest_pick_unit.sv
// ----------------------------------------------------------------------------
// ray_box_nearest_pick_unit
// Nearest axis-aligned box hit along a configured ray, Q20.12 fixed point.
// ----------------------------------------------------------------------------
// One box item is taken at a time; the input is not ready while a box is
// being tested. An ineligible box (or one whose slot is out of range) goes
// straight to S_FIN. An eligible box is tested axis by axis in S_AXIS, and
// each slab quotient runs through one shared restoring divider that yields
// one quotient bit per cycle over a 45-bit numerator; a parallel axis is
// settled in S_AXIS without the divider. The result of a pick is issued
// on the box with tlast and waits in an output register; the block only
// stalls if a second result arrives before the first is taken.
module ray_box_nearest_pick_unit #(
    parameter int MAX_SLOTS = rbnp_pkg::MaxSlotsDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rbnp_pkg::CfgAddrW-1:0]       i_cfg_addr,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cx[31:0] cy[63:32] cz[95:64] ex[126:96] ey[157:127] ez[188:158]
    // slot[198:189] zero[199]
    input  logic [rbnp_pkg::InDataW-1:0]        s_axis_tdata,
    input  logic                                s_axis_tlast,
    // eligible
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit_index[9:0] hit_distance[41:10] zero[47:42]
    output logic [rbnp_pkg::OutDataW-1:0]       m_axis_tdata,
    // hit_found
    output logic                                m_axis_tuser
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AXIS = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam int NW = rbnp_pkg::NumW;
    localparam int TW = rbnp_pkg::TW;

    logic [2:0]                     r_state;
    logic signed [31:0]             r_org [3];
    logic signed [31:0]             r_dir [3];
    logic [31:0]                    r_far;
    logic [rbnp_pkg::ThrW-1:0]      r_thr;

    logic signed [31:0]             r_cen [3];
    logic [rbnp_pkg::ExtW-1:0]      r_ext [3];
    logic [rbnp_pkg::SlotW-1:0]     r_slot;
    logic                           r_elig;
    logic                           r_last;
    logic                           r_ok;
    logic [1:0]                     r_axis;
    logic                           r_k;

    logic [NW-1:0]                  r_num;
    logic [NW-1:0]                  r_quo;
    logic [31:0]                    r_rem;
    logic [31:0]                    r_dmag;
    logic                           r_qneg;
    logic [rbnp_pkg::CntW-1:0]      r_cnt;
    logic signed [TW-1:0]           r_t0;
    logic signed [TW-1:0]           r_t1;
    logic signed [TW-1:0]           r_tmin;
    logic signed [TW-1:0]           r_tmax;

    logic [31:0]                    r_best;
    logic [rbnp_pkg::SlotW-1:0]     r_best_slot;
    logic                           r_any;

    logic                           r_out_valid;
    logic                           r_out_found;
    logic [rbnp_pkg::SlotW-1:0]     r_out_index;
    logic [31:0]                    r_out_dist;

    logic signed [31:0]                 w_org;
    logic signed [31:0]                 w_dir;
    logic signed [rbnp_pkg::BoundW-1:0] w_lo;
    logic signed [rbnp_pkg::BoundW-1:0] w_hi;
    logic [31:0]                        w_dir_mag;
    logic                               w_parallel;
    logic                               w_outside;
    logic signed [rbnp_pkg::DiffW-1:0]  w_diff;
    logic [rbnp_pkg::DiffW-1:0]         w_diff_mag;
    logic [32:0]                        w_rem_sh;
    logic                               w_qbit;
    logic [NW-1:0]                      w_quo_next;
    logic [31:0]                        w_tmag;
    logic signed [TW-1:0]               w_tsat;
    logic signed [TW-1:0]               w_nv;
    logic signed [TW-1:0]               w_fv;
    logic signed [TW-1:0]               w_tmin_n;
    logic signed [TW-1:0]               w_tmax_n;
    logic                               w_take;
    logic [31:0]                        w_best_n;
    logic [rbnp_pkg::SlotW-1:0]         w_slot_n;
    logic                               w_any_n;
    logic                               w_out_free;
    logic                               w_slot_ok;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {6'd0, r_out_dist, r_out_index};

    assign w_slot_ok = ({22'd0, s_axis_tdata[198:189]} < MAX_SLOTS);

    assign w_org     = r_org[r_axis];
    assign w_dir     = r_dir[r_axis];
    assign w_lo      = rbnp_pkg::BoundW'(r_cen[r_axis])
                       - rbnp_pkg::BoundW'({1'b0, r_ext[r_axis]});
    assign w_hi      = rbnp_pkg::BoundW'(r_cen[r_axis])
                       + rbnp_pkg::BoundW'({1'b0, r_ext[r_axis]});
    assign w_dir_mag = w_dir[31] ? 32'(-w_dir) : w_dir;
    assign w_parallel = (w_dir == 32'sd0) || (w_dir_mag < {16'd0, r_thr});
    assign w_outside = (rbnp_pkg::BoundW'(w_org) < w_lo) || (rbnp_pkg::BoundW'(w_org) > w_hi);
    assign w_diff    = (r_k ? rbnp_pkg::DiffW'(w_hi) : rbnp_pkg::DiffW'(w_lo))
                       - rbnp_pkg::DiffW'(w_org);
    assign w_diff_mag = w_diff[rbnp_pkg::DiffW-1] ? rbnp_pkg::DiffW'(-w_diff) : w_diff;

    assign w_rem_sh   = {r_rem, r_num[NW-1]};
    assign w_qbit     = (w_rem_sh >= {1'b0, r_dmag});
    assign w_quo_next = {r_quo[NW-2:0], w_qbit};

    assign w_tmag = (r_quo > NW'(r_far)) ? r_far : r_quo[31:0];
    assign w_tsat = r_qneg ? -TW'({2'b00, w_tmag}) : TW'({2'b00, w_tmag});

    assign w_nv     = (r_t0 < r_t1) ? r_t0 : r_t1;
    assign w_fv     = (r_t0 > r_t1) ? r_t0 : r_t1;
    assign w_tmin_n = (w_nv > r_tmin) ? w_nv : r_tmin;
    assign w_tmax_n = (w_fv < r_tmax) ? w_fv : r_tmax;

    assign w_take   = r_elig && r_ok && (!r_any || (r_tmin[31:0] < r_best));
    assign w_best_n = w_take ? r_tmin[31:0] : r_best;
    assign w_slot_n = w_take ? r_slot : r_best_slot;
    assign w_any_n  = r_any || w_take;
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= rbnp_pkg::DirZReset;
            r_far    <= rbnp_pkg::FarReset;
            r_thr    <= rbnp_pkg::ThrReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                rbnp_pkg::RegOrgX: r_org[0] <= i_cfg_data;
                rbnp_pkg::RegOrgY: r_org[1] <= i_cfg_data;
                rbnp_pkg::RegOrgZ: r_org[2] <= i_cfg_data;
                rbnp_pkg::RegDirX: r_dir[0] <= i_cfg_data;
                rbnp_pkg::RegDirY: r_dir[1] <= i_cfg_data;
                rbnp_pkg::RegDirZ: r_dir[2] <= i_cfg_data;
                rbnp_pkg::RegFar:  r_far    <= i_cfg_data;
                rbnp_pkg::RegThr:  r_thr    <= i_cfg_data[rbnp_pkg::ThrW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_best      <= '0;
            r_best_slot <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && !(r_state == S_FIN && r_last)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cen[0] <= s_axis_tdata[31:0];
                        r_cen[1] <= s_axis_tdata[63:32];
                        r_cen[2] <= s_axis_tdata[95:64];
                        r_ext[0] <= s_axis_tdata[126:96];
                        r_ext[1] <= s_axis_tdata[157:127];
                        r_ext[2] <= s_axis_tdata[188:158];
                        r_slot   <= s_axis_tdata[198:189];
                        r_elig   <= s_axis_tuser && w_slot_ok;
                        r_last   <= s_axis_tlast;
                        r_ok     <= 1'b1;
                        r_axis   <= 2'd0;
                        r_tmin   <= '0;
                        r_tmax   <= TW'({2'b00, r_far});
                        r_state  <= (s_axis_tuser && w_slot_ok) ? S_AXIS : S_FIN;
                    end
                end
                S_AXIS: begin
                    r_k <= 1'b0;
                    if (w_parallel) begin
                        if (w_outside) begin
                            r_ok    <= 1'b0;
                            r_state <= S_FIN;
                        end else if (r_axis == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end else begin
                        r_dmag  <= w_dir_mag;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_num   <= {w_diff_mag[32:0], 12'd0};
                    r_quo   <= '0;
                    r_rem   <= '0;
                    r_qneg  <= w_diff[rbnp_pkg::DiffW-1] ^ w_dir[31];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == rbnp_pkg::CntW'(NW)) begin
                        if (!r_k) begin
                            r_t0    <= w_tsat;
                            r_k     <= 1'b1;
                            r_state <= S_LOAD;
                        end else begin
                            r_t1    <= w_tsat;
                            r_state <= S_UPD;
                        end
                    end else begin
                        r_rem <= w_qbit ? 32'(w_rem_sh - {1'b0, r_dmag}) : w_rem_sh[31:0];
                        r_quo <= w_quo_next;
                        r_num <= {r_num[NW-2:0], 1'b0};
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_UPD: begin
                    r_tmin <= w_tmin_n;
                    r_tmax <= w_tmax_n;
                    if (w_tmax_n < w_tmin_n) begin
                        r_ok    <= 1'b0;
                        r_state <= S_FIN;
                    end else if (r_axis == 2'd2) begin
                        r_state <= S_FIN;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_AXIS;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_best      <= w_best_n;
                        r_best_slot <= w_slot_n;
                        r_any       <= w_any_n;
                        r_state     <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= w_any_n;
                        r_out_index <= w_any_n ? w_slot_n : '0;
                        r_out_dist  <= w_any_n ? w_best_n : '0;
                        r_best      <= '0;
                        r_best_slot <= '0;
                        r_any       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/rbnp_checker.sv
// ----------------------------------------------------------------------------
// rbnp_checker
// Port-level checks of the ray/box nearest pick, bound to the top level.
// ----------------------------------------------------------------------------
module rbnp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [rbnp_pkg::OutDataW-1:0]      m_axis_tdata,
    input logic                               m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("no-hit result carries nonzero index or distance");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready again right after taking an item");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind ray_box_nearest_pick_unit rbnp_checker u_rbnp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the ray/box nearest pick. Programs several rays,
// streams box runs, mostly with random handshake gaps, and compares each pick
// result against an in-bench slab-test predictor.
// ----------------------------------------------------------------------------

class pick_scoreboard;
    logic [31:0] regs [8];
    logic [31:0] best_dist;
    logic [9:0]  best_slot;
    bit          any_hit;
    logic [42:0] pending_q [$];
    int          mismatches;
    int          picks;
    int          hits;

    function void reset_state();
        for (int i = 0; i < 8; i++) regs[i] = '0;
        regs[rbnp_pkg::RegDirZ] = rbnp_pkg::DirZReset;
        regs[rbnp_pkg::RegFar]  = rbnp_pkg::FarReset;
        regs[rbnp_pkg::RegThr]  = 32'(rbnp_pkg::ThrReset);
        best_dist = '0;
        best_slot = '0;
        any_hit   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        regs[idx] = (idx == rbnp_pkg::RegThr) ? {16'd0, val[15:0]} : val;
    endfunction

    function longint clamp(longint t, longint lim);
        if (t > lim) return lim;
        if (t < -lim) return -lim;
        return t;
    endfunction

    function bit slab(longint c[3], longint e[3], output longint entry_d);
        longint lim, thr, tmin, tmax, org, dir, lo, hi, mag, t0, t1, nv, fv;
        lim  = longint'({32'd0, regs[rbnp_pkg::RegFar]});
        thr  = longint'(regs[rbnp_pkg::RegThr][15:0]);
        tmin = 0;
        tmax = lim;
        entry_d = 0;
        for (int a = 0; a < 3; a++) begin
            org = longint'($signed(regs[a]));
            dir = longint'($signed(regs[3 + a]));
            lo  = c[a] - e[a];
            hi  = c[a] + e[a];
            mag = dir < 0 ? -dir : dir;
            if (dir == 0 || mag < thr) begin
                if (org < lo || org > hi) return 0;
                continue;
            end
            t0 = clamp(((lo - org) * 4096) / dir, lim);
            t1 = clamp(((hi - org) * 4096) / dir, lim);
            nv = t0 < t1 ? t0 : t1;
            fv = t0 > t1 ? t0 : t1;
            if (nv > tmin) tmin = nv;
            if (fv < tmax) tmax = fv;
            if (tmax < tmin) return 0;
        end
        entry_d = tmin >= 0 ? tmin : tmax;
        return tmax >= 0;
    endfunction

    function void note_box(logic [199:0] data, bit elig, bit last);
        longint c[3], e[3], d;
        logic [9:0] slot;
        slot = data[198:189];
        for (int i = 0; i < 3; i++) begin
            c[i] = longint'($signed(data[32*i +: 32]));
            e[i] = longint'({1'b0, data[96 + 31*i +: 31]});
        end
        if (elig && slot < rbnp_pkg::MaxSlotsDefault) begin
            if (slab(c, e, d)) begin
                if (!any_hit || d[31:0] < best_dist) begin
                    best_dist = d[31:0];
                    best_slot = slot;
                    any_hit   = 1;
                end
            end
        end
        if (last) begin
            pending_q.push_back(any_hit ? {1'b1, best_dist, best_slot} : 43'd0);
            best_dist = '0;
            best_slot = '0;
            any_hit   = 0;
        end
    endfunction

    function void check_pick(logic [47:0] data, logic found);
        logic [42:0] exp_v, got;
        got = {found, data[41:0]};
        picks++;
        if (found) hits++;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pick result %h", got);
            return;
        end
        exp_v = pending_q.pop_front();
        if (got !== exp_v || data[47:42] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"pick mismatch: exp found=%0d idx=%0d dist=%h, ",
                          "got found=%0d idx=%0d dist=%h"},
                         exp_v[42], exp_v[9:0], exp_v[41:10], found, data[9:0], data[41:10]);
        end
    endfunction
endclass

module tb_top;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [rbnp_pkg::CfgAddrW-1:0] i_cfg_addr;
    logic [31:0]                   i_cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [rbnp_pkg::InDataW-1:0]  s_axis_tdata;
    logic                          s_axis_tlast;
    logic                          s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [rbnp_pkg::OutDataW-1:0] m_axis_tdata;
    logic                          m_axis_tuser;

    pick_scoreboard sb;
    int  idle_cycles;
    bit  no_gaps;
    bit  timed_out;
    int  box_count;

    ray_box_nearest_pick_unit u_top (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pick(m_axis_tdata, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int n;
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (no_gaps) m_axis_tready = 1;
            else if ($urandom_range(0, 5) == 0) begin
                m_axis_tready = 0;
                n = $urandom_range(1, 12);
                repeat (n - 1) @(negedge i_clk);
            end else m_axis_tready = 1;
        end
    end

    initial begin
        wait (idle_cycles > 5000);
        timed_out = 1;
        $display("Regression FAIL");
        $finish;
    end

    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid = 1;
        i_cfg_addr  = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic send_box(logic [199:0] data, bit elig, bit last);
        if (!no_gaps && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 12)) @(negedge i_clk);
        s_axis_tvalid = 1;
        s_axis_tdata  = data;
        s_axis_tuser  = elig;
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_box(data, elig, last);
        box_count++;
        @(negedge i_clk);
        s_axis_tvalid = 0;
    endtask

    function automatic logic [199:0] make_box(logic [31:0] cx, cy, cz,
                                              logic [30:0] ex, ey, ez, logic [9:0] slot);
        return {1'b0, slot, ez, ey, ex, cz, cy, cx};
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            default: return 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    function automatic logic [199:0] rand_box();
        logic [31:0] c [3];
        logic [30:0] e [3];
        int m;
        m = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            c[i] = rand_coord(m == 0 ? 0 : 1);
            e[i] = (m == 1) ? 31'($urandom) : 31'($urandom_range(0, 120000));
        end
        return make_box(c[0], c[1], c[2], e[0], e[1], e[2], 10'($urandom));
    endfunction

    task automatic random_ray(bit wild);
        for (int i = 0; i < 3; i++) begin
            write_cfg(3'(i), wild ? $urandom : 32'($signed($urandom_range(0, 80000)) - 40000));
            write_cfg(3'(3 + i), $urandom_range(0, 6) == 0 ? 32'd0
                      : (wild ? $urandom : 32'($signed($urandom_range(0, 16384)) - 8192)));
        end
    endtask

    initial begin
        logic [199:0] b;
        int runlen;
        sb = new();
        sb.reset_state();
        idle_cycles = 0; no_gaps = 0; timed_out = 0; box_count = 0;
        i_rst_n = 0; i_cfg_valid = 0; i_cfg_addr = '0; i_cfg_data = '0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tlast = 0; s_axis_tuser = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: reset ray down -z
        send_box(make_box(0, 0, 32'hFFFF_6000, 31'd4096, 31'd4096, 31'd4096, 10'd5), 1, 0);
        send_box(make_box(0, 0, 32'hFFFF_6000, 31'd4096, 31'd4096, 31'd4096, 10'd9), 1, 0);
        send_box(make_box(32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF, 31'd0, 31'd0, 10'd1023), 1, 0);
        send_box(make_box(0, 0, 32'hFFFF_0000, 31'd8192, 31'd8192, 31'd8192, 10'd7), 0, 1);
        send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 10'd3), 1, 1);
        send_box(make_box(40960, 0, 0, 31'd4096, 31'd4096, 31'd4096, 10'd2), 1, 1);
        send_box(make_box(0, 0, 0, 31'd4096, 31'd4096, 31'd4096, 10'd0), 1, 1);
        drain();
        write_cfg(rbnp_pkg::RegOrgX, 32'h8000_0000); write_cfg(rbnp_pkg::RegOrgY, 32'h7FFF_FFFF);
        write_cfg(rbnp_pkg::RegOrgZ, 0); write_cfg(rbnp_pkg::RegDirX, 32'h7FFF_FFFF);
        write_cfg(rbnp_pkg::RegDirY, 32'h8000_0000); write_cfg(rbnp_pkg::RegDirZ, 32'd100);
        write_cfg(rbnp_pkg::RegFar, 32'hFFFF_FFFF); write_cfg(rbnp_pkg::RegThr, 32'd0);
        send_box(make_box(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 10'd12), 1, 0);
        send_box(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          31'd0, 31'd0, 31'd0, 10'd13), 1, 1);
        drain();
        write_cfg(rbnp_pkg::RegFar, 0); write_cfg(rbnp_pkg::RegThr, 32'd65535);
        send_box(make_box(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 10'd700), 1, 1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_ray(ph == 3);
            case (ph)
                1: write_cfg(rbnp_pkg::RegFar, 32'hFFFF_FFFF);
                2: write_cfg(rbnp_pkg::RegFar, $urandom_range(0, 200000));
                default: write_cfg(rbnp_pkg::RegFar, $urandom);
            endcase
            write_cfg(rbnp_pkg::RegThr, ph == 4 ? 32'd65535 : $urandom_range(0, 3000));
            if (ph == 7) no_gaps = 1;
            for (int k = 0; k < 140; ) begin
                runlen = $urandom_range(1, 8);
                for (int j = 0; j < runlen; j++) begin
                    b = rand_box();
                    send_box(b, $urandom_range(0, 5) != 0, j == runlen - 1);
                    k++;
                end
            end
            drain();
        end
        drain();
        $display("Covered %0d boxes over %0d picks, %0d with a hit.", box_count, sb.picks, sb.hits);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0 && !timed_out)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
